FILE: rtl/sparse_table_range_query_assert.svh
// assertion macros for the sparse table range query rtl
`ifndef SPARSE_TABLE_RANGE_QUERY_ASSERT_SVH
`define SPARSE_TABLE_RANGE_QUERY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srq_pkg.sv
// shared types, constants and the combine function of the sparse table engine
package srq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SIGN_BIT = 31;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_BUILD   = 2'd1,
    OP_QRY_DEC = 2'd2,
    OP_QRY_OVL = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_VALUE = 2'd2;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_RA,
    ST_BUILD_RB,
    ST_BUILD_WR,
    ST_QD_SCAN,
    ST_QD_LAST,
    ST_QO_RA,
    ST_QO_RB,
    ST_QO_CMB,
    ST_DONE
  } state_t;

  typedef struct packed {
    word_t answer;
    logic  status;
  } res_t;

  function automatic word_t srq_combine(word_t a, word_t b, logic mode);
    word_t res;
    if (mode == MODE_MIN) begin
      // flip the sign bit so an unsigned compare orders signed values
      res = ({~a[SIGN_BIT], a[SIGN_BIT-1:0]} < {~b[SIGN_BIT], b[SIGN_BIT-1:0]}) ? a : b;
    end else begin
      res = a + b;
    end
    return res;
  endfunction

endpackage

FILE: rtl/srq_chan_if.sv
// request and result channel interfaces of the sparse table engine
interface srq_in_if import srq_pkg::*; #(
  parameter int IDX_W = 10
);
  logic                     valid;
  logic                     ready;
  op_t                      opcode;
  logic [IDX_W-1:0]         left_index;
  logic [IDX_W-1:0]         right_index;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, opcode, left_index, right_index, element_value, input ready);
  modport sink   (input valid, opcode, left_index, right_index, element_value, output ready);
endinterface

interface srq_out_if import srq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;
  logic                     status;

  modport source (output valid, answer, status, input ready);
  modport sink   (input valid, answer, status, output ready);
endinterface

FILE: rtl/sparse_table_range_query.sv
// top level of the sparse table range query engine
//
// channel    dir  payload                                          handshake
// in_chan    in   opcode, left_index, right_index, element_value   valid / ready
// out_chan   out  answer, status                                   valid / ready
// cfg_*      in   cfg_index, cfg_wdata                             cfg_we, never stalls
//
// one request at a time; a decomposing query visits each level in use (at most LEVELS)
// from the top down, an overlapping query reads two blocks, and a build reads two entries
// and writes one for each table entry, all through the single read port of the level table ram
// reset is synchronous and clears control state and config; table contents are
// undefined until loaded or built
// a finished result waits in the output register; the next request is taken meanwhile
// and its result is held in the engine until the register frees up
`include "sparse_table_range_query_assert.svh"

module sparse_table_range_query import srq_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  srq_in_if.sink               in_chan,
  srq_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W = $clog2(LEVELS);
  localparam int AW    = LVL_W + IDX_W;
  localparam int DEPTH = LEVELS << IDX_W;

  logic [LEN_W-1:0] array_length_r;
  logic             combine_mode_r;
  word_t            neutral_value_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  word_t            mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  word_t            mem_rdata;

  logic             res_valid;
  logic             res_ready;
  res_t             res_data;

  logic             out_valid_r;
  res_t             out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r  <= LEN_W'(1);
      combine_mode_r  <= MODE_SUM;
      neutral_value_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ARRAY_LENGTH) begin
        array_length_r <= cfg_wdata[LEN_W-1:0];
      end
      if (cfg_index == CFG_COMBINE_MODE) begin
        combine_mode_r <= cfg_wdata[0];
      end
      if (cfg_index == CFG_NEUTRAL_VALUE) begin
        neutral_value_r <= cfg_wdata;
      end
    end
  end

  srq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srq_engine #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .array_length  (array_length_r),
    .combine_mode  (combine_mode_r),
    .neutral_value (neutral_value_r),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_data      (res_data)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res_data;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.answer = $signed(out_res_r.answer);
  assign out_chan.status = out_res_r.status;

  `SRQ_ASSERT_NOW(a_accept_when_free, in_chan.valid && in_chan.ready, !res_valid, "request taken while a result is pending")
  `SRQ_ASSERT_NOW(a_error_answer_zero, out_valid_r && (out_res_r.status == STATUS_ERR), out_res_r.answer == '0, "rejected request carries a nonzero answer")
  `SRQ_ASSERT_NOW(a_no_rw_same_entry, mem_we && mem_re, mem_waddr != mem_raddr, "table read and written at the same entry")
  `SRQ_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_data), "engine result dropped or changed while blocked")

endmodule

FILE: rtl/srq_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module srq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/srq_engine.sv
// sequencer that loads, builds and queries the level table through one ram
module srq_engine import srq_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS = 11,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int LEN_W = $clog2(MAX_ELEMENTS + 1),
  localparam int LVL_W = $clog2(LEVELS),
  localparam int AW = LVL_W + IDX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  srq_in_if.sink           in_chan,
  input  logic [LEN_W-1:0] array_length,
  input  logic             combine_mode,
  input  word_t            neutral_value,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output word_t            mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  word_t            mem_rdata,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res_data
);

  localparam int NW = IDX_W + 1;
  localparam int KW = $clog2(LEVELS + 1);
  localparam int BW = $clog2(NW + 1);
  localparam logic [NW-1:0] ONE_N = NW'(1);

  state_t           state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic [NW-1:0]    pos_r, pos_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  word_t            a_r, a_nxt;
  word_t            acc_r, acc_nxt;
  word_t            ans_r, ans_nxt;
  logic             sta_r, sta_nxt;

  logic [NW-1:0]    n_eff;
  logic [BW-1:0]    blen;
  logic [KW-1:0]    k_cnt;
  logic [LVL_W-1:0] top_lvl;
  logic [NW-1:0]    ovl_len;
  logic [BW-1:0]    flog;
  logic [LVL_W-1:0] ovl_lvl;
  logic [NW-1:0]    step;
  logic [NW-1:0]    half;
  logic [LVL_W-1:0] lvl_m1;
  logic [IDX_W-1:0] j_half;
  logic [IDX_W-1:0] ovl_right;
  logic             hit;
  word_t            acc_cur;
  op_t              op_in;
  logic [IDX_W-1:0] l_in;
  logic [IDX_W-1:0] r_in;
  logic             l_ok;
  logic             range_bad;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign op_in = in_chan.opcode;
  assign l_in  = in_chan.left_index;
  assign r_in  = in_chan.right_index;

  // effective length and number of levels in use
  always_comb begin
    if (array_length == '0) begin
      n_eff = ONE_N;
    end else if (array_length > LEN_W'(MAX_ELEMENTS)) begin
      n_eff = NW'(MAX_ELEMENTS);
    end else begin
      n_eff = NW'(array_length);
    end
  end

  always_comb begin
    blen = '0;
    for (int b = 0; b < NW; b++) begin
      if (n_eff[b]) begin
        blen = BW'(b + 1);
      end
    end
    if (int'(blen) > LEVELS) begin
      k_cnt = KW'(LEVELS);
    end else begin
      k_cnt = KW'(blen);
    end
  end

  assign top_lvl = LVL_W'(k_cnt - KW'(1));

  // block size of the overlapping query, capped to the top level
  assign ovl_len = NW'(r_r) - pos_r + ONE_N;

  always_comb begin
    flog = '0;
    for (int b = 0; b < NW; b++) begin
      if (ovl_len[b]) begin
        flog = BW'(b);
      end
    end
    if (int'(flog) > int'(top_lvl)) begin
      ovl_lvl = top_lvl;
    end else begin
      ovl_lvl = LVL_W'(flog);
    end
  end

  assign l_ok      = NW'(l_in) < n_eff;
  assign range_bad = (l_in > r_in) || (NW'(r_in) >= n_eff);

  assign lvl_m1    = lvl_r - LVL_W'(1);
  assign step      = ONE_N << lvl_r;
  assign half      = ONE_N << lvl_m1;
  assign j_half    = IDX_W'(NW'(j_r) + half);
  assign ovl_right = IDX_W'(NW'(r_r) + ONE_N - step);
  assign hit       = (rem_r >> lvl_r) != '0;
  // a read issued last cycle lands in the fold now
  assign acc_cur   = pend_r ? srq_combine(acc_r, mem_rdata, combine_mode) : acc_r;

  assign res_data  = '{answer: ans_r, status: sta_r};

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    r_nxt     = r_r;
    lvl_nxt   = lvl_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    acc_nxt   = acc_r;
    ans_nxt   = ans_r;
    sta_nxt   = sta_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          ans_nxt   = '0;
          sta_nxt   = STATUS_OK;
          state_nxt = ST_DONE;
          unique case (op_in)
            OP_LOAD: begin
              if (l_ok) begin
                mem_we    = 1'b1;
                mem_waddr = {LVL_W'(0), l_in};
                mem_wdata = word_t'(in_chan.element_value);
              end else begin
                sta_nxt = STATUS_ERR;
              end
            end
            OP_BUILD: begin
              if (k_cnt > KW'(1)) begin
                lvl_nxt   = LVL_W'(1);
                j_nxt     = '0;
                state_nxt = ST_BUILD_RA;
              end
            end
            OP_QRY_DEC: begin
              if (range_bad) begin
                sta_nxt = STATUS_ERR;
              end else begin
                acc_nxt   = neutral_value;
                pos_nxt   = NW'(l_in);
                rem_nxt   = NW'(r_in) - NW'(l_in) + ONE_N;
                lvl_nxt   = top_lvl;
                pend_nxt  = 1'b0;
                state_nxt = ST_QD_SCAN;
              end
            end
            OP_QRY_OVL: begin
              if (range_bad) begin
                sta_nxt = STATUS_ERR;
              end else begin
                pos_nxt   = NW'(l_in);
                r_nxt     = r_in;
                state_nxt = ST_QO_RA;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_BUILD_RA: begin
        mem_re    = 1'b1;
        mem_raddr = {lvl_m1, j_r};
        state_nxt = ST_BUILD_RB;
      end

      ST_BUILD_RB: begin
        mem_re    = 1'b1;
        mem_raddr = {lvl_m1, j_half};
        a_nxt     = mem_rdata;
        state_nxt = ST_BUILD_WR;
      end

      ST_BUILD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {lvl_r, j_r};
        mem_wdata = srq_combine(a_r, mem_rdata, combine_mode);
        // last block of this level ends exactly at the length
        if (NW'(j_r) + step == n_eff) begin
          if (lvl_r == top_lvl) begin
            state_nxt = ST_DONE;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            j_nxt     = '0;
            state_nxt = ST_BUILD_RA;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_BUILD_RA;
        end
      end

      ST_QD_SCAN: begin
        acc_nxt = acc_cur;
        if (hit) begin
          mem_re    = 1'b1;
          mem_raddr = {lvl_r, pos_r[IDX_W-1:0]};
          pos_nxt   = pos_r + step;
          rem_nxt   = rem_r - step;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (lvl_r == '0) begin
          state_nxt = ST_QD_LAST;
        end else begin
          lvl_nxt = lvl_m1;
        end
      end

      ST_QD_LAST: begin
        ans_nxt   = acc_cur;
        pend_nxt  = 1'b0;
        state_nxt = ST_DONE;
      end

      ST_QO_RA: begin
        mem_re    = 1'b1;
        mem_raddr = {ovl_lvl, pos_r[IDX_W-1:0]};
        lvl_nxt   = ovl_lvl;
        state_nxt = ST_QO_RB;
      end

      ST_QO_RB: begin
        mem_re    = 1'b1;
        mem_raddr = {lvl_r, ovl_right};
        a_nxt     = mem_rdata;
        state_nxt = ST_QO_CMB;
      end

      ST_QO_CMB: begin
        ans_nxt   = srq_combine(a_r, mem_rdata, combine_mode);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    r_r   <= r_nxt;
    lvl_r <= lvl_nxt;
    j_r   <= j_nxt;
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    ans_r <= ans_nxt;
    sta_r <= sta_nxt;
  end

endmodule

FILE: bench/tb.sv
// self-checking testbench for the sparse table range query engine
module tb import srq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS = 11;
  localparam int IDX_W = 10;
  localparam int STALL_LIMIT = 150000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int FILL_MAX = 300;

  typedef struct packed {
    op_t              opcode;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    word_t            element_value;
  } request_t;

  // mirror of the level table and registers, plus the queue of answers still owed
  class range_query_board;
    word_t       level_tbl [LEVELS][MAX_ELEMENTS];
    bit          filled    [LEVELS][MAX_ELEMENTS];
    logic [10:0] length_reg;
    logic        mode_reg;
    word_t       neutral_reg;
    res_t        pending_answers[$];
    int          fails;

    function new();
      length_reg = 11'd1;
      mode_reg = MODE_SUM;
      neutral_reg = '0;
      fails = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
      case (idx)
        CFG_ARRAY_LENGTH:  length_reg = value[10:0];
        CFG_COMBINE_MODE:  mode_reg = value[0];
        CFG_NEUTRAL_VALUE: neutral_reg = value;
        default: ;
      endcase
    endfunction

    // length in effect: zero counts as one, oversize is clipped
    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_ELEMENTS) return MAX_ELEMENTS;
      return length_reg;
    endfunction

    function int unsigned level_count(int unsigned n);
      int unsigned k;
      k = 0;
      while (k < 32 && (n >> k) != 0) k++;
      return (k > LEVELS) ? LEVELS : k;
    endfunction

    function word_t combine_pair(word_t a, word_t b);
      if (mode_reg == MODE_MIN) return ($signed(a) < $signed(b)) ? a : b;
      return a + b;
    endfunction

    function bit bad_range(request_t rq);
      return rq.left_index > rq.right_index || rq.right_index >= span();
    endfunction

    // answer of a well-formed query; blank flags a read of a never-written entry
    function word_t range_answer(request_t rq, output bit blank);
      int unsigned k, pos, lvl, width, tail;
      word_t acc;
      k = level_count(span());
      blank = 1'b0;
      if (rq.opcode == OP_QRY_DEC) begin
        acc = neutral_reg;
        pos = rq.left_index;
        for (int i = int'(k) - 1; i >= 0; i--) begin
          if (pos <= rq.right_index && (32'd1 << i) <= int'(rq.right_index) - pos + 1) begin
            blank |= !filled[i][pos];
            acc = combine_pair(acc, level_tbl[i][pos]);
            pos += 32'd1 << i;
          end
        end
      end else begin
        width = int'(rq.right_index) - int'(rq.left_index) + 1;
        lvl = 0;
        while ((width >> (lvl + 1)) != 0) lvl++;
        if (lvl > k - 1) lvl = k - 1;
        tail = int'(rq.right_index) - (1 << lvl) + 1;
        blank = !filled[lvl][rq.left_index] || !filled[lvl][tail];
        acc = combine_pair(level_tbl[lvl][rq.left_index], level_tbl[lvl][tail]);
      end
      return acc;
    endfunction

    function bit reads_blank(request_t rq);
      bit blank;
      word_t ignored;
      blank = 1'b0;
      if (rq.opcode == OP_BUILD) begin
        // a build pairs up every element below the length
        for (int j = 0; j < int'(span()); j++) blank |= span() > 1 && !filled[0][j];
      end else if (rq.opcode != OP_LOAD && !bad_range(rq)) begin
        ignored = range_answer(rq, blank);
      end
      return blank;
    endfunction

    function void note_request(request_t rq);
      res_t expected;
      int unsigned n, k, half;
      bit blank;
      n = span();
      k = level_count(n);
      expected.answer = '0;
      expected.status = STATUS_OK;
      case (rq.opcode)
        OP_LOAD: begin
          if (rq.left_index < n) begin
            level_tbl[0][rq.left_index] = rq.element_value;
            filled[0][rq.left_index] = 1'b1;
          end else begin
            expected.status = STATUS_ERR;
          end
        end
        OP_BUILD: begin
          for (int i = 1; i < int'(k); i++) begin
            half = 1 << (i - 1);
            for (int j = 0; j + (1 << i) <= int'(n); j++) begin
              level_tbl[i][j] = combine_pair(level_tbl[i-1][j], level_tbl[i-1][j+half]);
              filled[i][j] = filled[i-1][j] && filled[i-1][j+half];
            end
          end
        end
        default: begin
          if (bad_range(rq)) expected.status = STATUS_ERR;
          else expected.answer = range_answer(rq, blank);
        end
      endcase
      pending_answers.insert(pending_answers.size(), expected);
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(word_t answer, logic status);
      res_t expected;
      if (pending_answers.size() == 0) begin
        report($sformatf("result with nothing pending: answer %h status %0d", answer, status));
        return;
      end
      expected = pending_answers.pop_front();
      if (answer !== expected.answer)
        report($sformatf("answer mismatch: expected %h, got %h", expected.answer, answer));
      if (status !== expected.status)
        report($sformatf("status mismatch: expected %0d, got %0d", expected.status, status));
    endfunction

    function int pending_count();
      return pending_answers.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_wdata;
  bit                   calm = 1'b0;
  bit                   hold_req = 1'b0;
  int                   idle_cycles = 0;
  range_query_board     sb;

  srq_in_if #(.IDX_W(IDX_W)) in_chan();
  srq_out_if out_chan();

  sparse_table_range_query #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS(LEVELS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.answer, out_chan.status);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic request_t make_request(op_t op, int unsigned l, int unsigned r, word_t v);
    request_t rq;
    rq.opcode = op;
    rq.left_index = IDX_W'(l);
    rq.right_index = IDX_W'(r);
    rq.element_value = v;
    return rq;
  endfunction

  function automatic word_t draw_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return word_t'($urandom_range(15));
      3: return -word_t'($urandom_range(16));
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t draw_request(int unsigned n);
    request_t rq;
    int unsigned pick, build_pct, lo;
    pick = $urandom_range(99);
    // builds are drawn less often for big tables, as a build rewrites every level
    build_pct = (n > 256) ? 2 : 10;
    rq = make_request(OP_LOAD, $urandom_range(1023), $urandom_range(1023), draw_value());
    if (pick < 35) begin
      if ($urandom_range(9) != 0) rq.left_index = IDX_W'($urandom_range(n - 1));
    end else if (pick < 35 + build_pct) begin
      rq.opcode = OP_BUILD;
    end else begin
      rq.opcode = $urandom_range(1) ? OP_QRY_OVL : OP_QRY_DEC;
      // most ranges well formed, the rest keep the raw indexes
      if ($urandom_range(9) != 0) begin
        lo = $urandom_range(n - 1);
        rq.left_index = IDX_W'(lo);
        rq.right_index = IDX_W'($urandom_range(n - 1, lo));
      end
    end
    return rq;
  endfunction

  function automatic request_t safe_request(int unsigned n);
    request_t rq;
    rq = draw_request(n);
    for (int t = 0; t < 20 && sb.reads_blank(rq); t++) rq = draw_request(n);
    if (sb.reads_blank(rq)) rq = make_request(OP_LOAD, $urandom_range(n - 1), 0, draw_value());
    return rq;
  endfunction

  // called right after a rising edge; returns at the edge where the request is taken
  task automatic issue_request(request_t rq);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 32) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= rq.opcode;
    in_chan.left_index <= rq.left_index;
    in_chan.right_index <= rq.right_index;
    in_chan.element_value <= rq.element_value;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(rq);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, word_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_regs(int unsigned len, logic mode, word_t neutral);
    drain();
    repeat (2) @(posedge clk);
    cfg_write(CFG_ARRAY_LENGTH, len);
    cfg_write(CFG_COMBINE_MODE, word_t'(mode));
    cfg_write(CFG_NEUTRAL_VALUE, neutral);
  endtask

  task automatic fill_elements(int unsigned n);
    for (int j = 0; j < int'(n); j++)
      if (!sb.filled[0][j])
        issue_request(make_request(OP_LOAD, j, $urandom_range(1023), draw_value()));
  endtask

  task automatic directed_requests();
    word_t corner_vals [8] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0,
                               32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_3039};
    set_regs(8, MODE_SUM, 32'h0);
    for (int j = 0; j < 8; j++)
      issue_request(make_request(OP_LOAD, j, 0, corner_vals[j]));
    // load past the length is refused
    issue_request(make_request(OP_LOAD, 1023, 1023, 32'hdead_beef));
    issue_request(make_request(OP_BUILD, 0, 0, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 0, 7, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 3, 3, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 1, 6, 32'h0));
    // overlapping blocks double count under sum
    issue_request(make_request(OP_QRY_OVL, 0, 7, 32'h0));
    issue_request(make_request(OP_QRY_OVL, 2, 4, 32'h0));
    issue_request(make_request(OP_QRY_OVL, 0, 0, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 5, 2, 32'h0));
    issue_request(make_request(OP_QRY_OVL, 0, 8, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 1023, 1023, 32'hffff_ffff));
    set_regs(8, MODE_MIN, 32'h7fff_ffff);
    issue_request(make_request(OP_BUILD, 1023, 1023, 32'hffff_ffff));
    issue_request(make_request(OP_QRY_DEC, 0, 7, 32'h0));
    issue_request(make_request(OP_QRY_OVL, 1, 6, 32'h0));
    issue_request(make_request(OP_QRY_DEC, 2, 5, 32'h0));
    issue_request(make_request(OP_QRY_OVL, 7, 7, 32'h0));
  endtask

  task automatic run_phase(int unsigned len, logic mode, word_t neutral, int count,
                           bit stressed);
    int unsigned n;
    set_regs(len, mode, neutral);
    n = sb.span();
    calm = stressed;
    // a few requests against the table left from the previous setting
    repeat (6) issue_request(safe_request(n));
    // full-size tables stay partly loaded and unbuilt
    if (int'(n) <= FILL_MAX) begin
      fill_elements(n);
      issue_request(make_request(OP_BUILD, $urandom_range(1023), $urandom_range(1023),
                                 $urandom()));
    end
    for (int i = 0; i < count; i++) begin
      if (stressed && i == count / 3) hold_req = 1'b1;
      if (stressed && i == 2 * count / 3) drain();
      issue_request(safe_request(n));
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ARRAY_LENGTH;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_LOAD;
    in_chan.left_index = '0;
    in_chan.right_index = '0;
    in_chan.element_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_requests();
    run_phase(0, MODE_SUM, 32'h7fff_ffff, 15, 1'b0);
    run_phase(1, MODE_MIN, 32'h8000_0000, 15, 1'b0);
    run_phase(2, MODE_SUM, $urandom(), 20, 1'b0);
    run_phase(13, MODE_MIN, 32'h7fff_ffff, 45, 1'b1);
    run_phase(37, MODE_SUM, 32'h8000_0000, 40, 1'b0);
    run_phase(64, MODE_MIN, $urandom(), 40, 1'b0);
    run_phase(1024, MODE_MIN, 32'h7fff_ffff, 30, 1'b0);
    run_phase(2047, MODE_SUM, 32'h0, 20, 1'b0);
    run_phase(5, MODE_MIN, $urandom(), 40, 1'b0);
    run_phase(100, MODE_SUM, $urandom(), 40, 1'b0);
    run_phase(9, MODE_MIN, 32'h8000_0000, 15, 1'b0);
    run_phase(300, MODE_MIN, $urandom(), 40, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/srq_pkg.sv
rtl/srq_chan_if.sv
rtl/srq_ram.sv
rtl/srq_engine.sv
rtl/sparse_table_range_query.sv
bench/tb.sv
